### rtl/core/mte_pkg.sv
// shared types and constants for the multi-tap echo block
`default_nettype none
package mte_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int TERM_W     = 17;
	localparam int PROD_W     = 33;
	localparam int GAIN_FRAC  = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DELAY_W    = 13;
	localparam int COUNT_W    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd2;

	localparam logic [DELAY_W-1:0]         DELAY_RST = 13'd1000;
	localparam logic [COUNT_W-1:0]         COUNT_RST = 4'd1;
	localparam logic signed [SAMPLE_W-1:0] GAIN_RST  = 16'sd16384;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_MUL,
		ST_SCALE,
		ST_ACC,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

### rtl/core/multi_tap_echo.sv
// multi-tap echo: per-channel sample history, tap sum over one shared multiplier
// each tap k costs a history read, a load, k multiply/scale passes and an accumulate
// a new input is taken only after the previous result has entered the output register
// the single multiplier is used k times for tap k
// reset clears control state, config registers, pointers, wrap flags and out_valid; the history ram is not cleared,
// a per-channel wrap flag makes never-written slots read as zero
`default_nettype none
module multi_tap_echo #(
	parameter int MAX_DELAY  = 4096,
	parameter int MAX_ECHOES = 8,
	parameter int CHANNELS   = 2
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [mte_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [mte_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 channel,
	input  wire logic signed [mte_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      channel_out,
	output logic signed [mte_pkg::SAMPLE_W-1:0]       sample_out,
	output logic                                      clipped
);
	import mte_pkg::*;

	localparam int HIST_LEN = MAX_DELAY * MAX_ECHOES;
	localparam int PTR_W    = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	localparam int BACK_W   = $clog2(HIST_LEN + 1) + 1;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH    = CHANNELS * HIST_LEN;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int N_W      = $clog2(MAX_ECHOES + 1);
	localparam int SUM_W    = TERM_W + $clog2(MAX_ECHOES + 1) + 1;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

	// configuration registers
	logic [DELAY_W-1:0]         delay_q;
	logic [COUNT_W-1:0]         count_q;
	logic signed [SAMPLE_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			count_q <= COUNT_RST;
			gain_q  <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELAY: delay_q <= cfg_data[DELAY_W-1:0];
				CFG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				CFG_GAIN:  gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped settings, taken at the start of a transaction
	logic [BACK_W-1:0] d_clamp;
	logic [N_W-1:0]    n_clamp;

	always_comb begin
		if (delay_q == '0)
			d_clamp = BACK_W'(1);
		else if (32'(delay_q) > MAX_DELAY)
			d_clamp = BACK_W'(MAX_DELAY);
		else
			d_clamp = BACK_W'(delay_q);
		if (32'(count_q) > MAX_ECHOES)
			n_clamp = N_W'(MAX_ECHOES);
		else
			n_clamp = N_W'(count_q);
	end

	state_t state_q, state_d;

	logic [CH_W-1:0]            ch_q;
	logic                       chf_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] g_q;
	logic [BACK_W-1:0]          d_q;
	logic [BACK_W-1:0]          back_q;
	logic [N_W-1:0]             n_q;
	logic [N_W-1:0]             k_q;
	logic [N_W-1:0]             mcnt_q;
	logic signed [TERM_W-1:0]   term_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0]        rd_data_q;
	logic                       tap_ok_q;

	logic [PTR_W-1:0] ptr_q  [CHANNELS];
	logic             wrap_q [CHANNELS];

	logic accept, mem_we, out_load;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = (n_clamp == '0) ? ST_WRITE : ST_READ;
			end
			ST_READ:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: state_d = (mcnt_q + 1'b1 == k_q) ? ST_ACC : ST_MUL;
			ST_ACC:   state_d = (k_q == n_q) ? ST_WRITE : ST_READ;
			ST_WRITE: begin
				mem_we  = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// tap address: ring position back_q samples behind the write pointer
	logic [PTR_W-1:0]  cur_ptr;
	logic              cur_wrap;
	logic [BACK_W-1:0] cur_ext;
	logic [BACK_W-1:0] idx_ext;
	logic              tap_ok;
	logic [ADDR_W-1:0] ch_base;
	logic [ADDR_W-1:0] mem_addr;

	assign cur_ptr  = ptr_q[ch_q];
	assign cur_wrap = wrap_q[ch_q];
	assign cur_ext  = BACK_W'(cur_ptr);
	assign ch_base  = ADDR_W'(ch_q) * ADDR_W'(HIST_LEN);

	always_comb begin
		if (back_q <= cur_ext)
			idx_ext = cur_ext - back_q;
		else
			idx_ext = cur_ext + BACK_W'(HIST_LEN) - back_q;
		// slots not yet written since reset read as zero
		tap_ok = cur_wrap || (back_q <= cur_ext);
		if (mem_we)
			mem_addr = ch_base + ADDR_W'(cur_ptr);
		else
			mem_addr = ch_base + ADDR_W'(idx_ext[PTR_W-1:0]);
	end

	// history ram, one port
	logic [SAMPLE_W-1:0] hist_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we)
			hist_mem[mem_addr] <= x_q;
		else if (state_q == ST_READ)
			rd_data_q <= hist_mem[mem_addr];
	end

	// shared multiplier and truncating scale toward zero
	logic signed [PROD_W-1:0] mul_res;
	logic signed [PROD_W-1:0] biased;
	logic signed [PROD_W-1:0] scaled;

	assign mul_res = PROD_W'(term_q) * PROD_W'(g_q);
	assign biased  = prod_q[PROD_W-1] ? prod_q + PROD_W'(32767) : prod_q;
	assign scaled  = biased >>> GAIN_FRAC;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ch_q   <= (CHANNELS > 1) ? CH_W'(channel) : '0;
					chf_q  <= channel;
					x_q    <= sample_in;
					g_q    <= gain_q;
					d_q    <= d_clamp;
					back_q <= d_clamp;
					n_q    <= n_clamp;
					k_q    <= N_W'(1);
					sum_q  <= SUM_W'(sample_in);
				end
			end
			ST_READ:  tap_ok_q <= tap_ok;
			ST_LOAD: begin
				term_q <= tap_ok_q ? TERM_W'($signed(rd_data_q)) : '0;
				mcnt_q <= '0;
			end
			ST_MUL:   prod_q <= mul_res;
			ST_SCALE: begin
				term_q <= scaled[TERM_W-1:0];
				mcnt_q <= mcnt_q + 1'b1;
			end
			ST_ACC: begin
				sum_q  <= sum_q + SUM_W'(term_q);
				k_q    <= k_q + 1'b1;
				back_q <= back_q + d_q;
			end
			default: ;
		endcase
	end

	// ring pointers and wrap flags per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				ptr_q[c]  <= '0;
				wrap_q[c] <= 1'b0;
			end
		end else if (mem_we) begin
			if (32'(cur_ptr) == HIST_LEN - 1) begin
				ptr_q[ch_q]  <= '0;
				wrap_q[ch_q] <= 1'b1;
			end else begin
				ptr_q[ch_q] <= cur_ptr + 1'b1;
			end
		end
	end

	// output register with saturation
	logic                       out_valid_q;
	logic                       channel_out_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			channel_out_q <= chf_q;
			if (sum_q > SAT_HI) begin
				sample_out_q <= 16'sh7fff;
				clipped_q    <= 1'b1;
			end else if (sum_q < SAT_LO) begin
				sample_out_q <= 16'sh8000;
				clipped_q    <= 1'b1;
			end else begin
				sample_out_q <= sum_q[SAMPLE_W-1:0];
				clipped_q    <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = channel_out_q;
	assign sample_out  = sample_out_q;
	assign clipped     = clipped_q;

	// tap index stays within the echo count while taps are summed
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_LOAD || state_q == ST_MUL ||
		 state_q == ST_SCALE || state_q == ST_ACC) |-> (k_q >= N_W'(1) && k_q <= n_q))
		else $error("tap index outside echo count");

	// tap k reads k spacings back
	a_back_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (32'(back_q) == 32'(k_q) * 32'(d_q)))
		else $error("tap distance does not match tap index");

	// gain applied no more than k times per tap
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_SCALE) |-> (mcnt_q < k_q))
		else $error("gain applied too often");

	// exactly one history write per accepted transaction, before the result
	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (state_q == ST_DONE && !mem_we))
		else $error("history write out of sequence");

endmodule
`default_nettype wire
